// ----- sv/fwca_pkg.sv -----
// ----------------------------------------------------------------------------
// fwca_pkg
// Shared widths, defaults and the closed-bin record passed from the bin
// accumulator to the divider through the bin queue.
// ----------------------------------------------------------------------------
`default_nettype none

package fwca_pkg;

   // fixed accumulator and result widths
   localparam int SUM_BITS  = 40;
   localparam int WSUM_BITS = 24;

   // configuration register file
   localparam int BIN_WIDTH_BITS = 9;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic REG_BIN_WIDTH = 1'b0;
   localparam logic [BIN_WIDTH_BITS-1:0] BIN_WIDTH_RESET = 9'd1;

   // depth of the queue between accumulator and divider
   localparam int QUEUE_DEPTH = 2;

   // parameter defaults
   localparam int DEF_MAX_BIN_WIDTH = 256;
   localparam int DEF_DATA_BITS     = 16;
   localparam int DEF_WEIGHT_BITS   = 16;

   // one closed bin, waiting for its division
   typedef struct packed {
      logic [SUM_BITS-1:0]  sum_re;
      logic [SUM_BITS-1:0]  sum_im;
      logic [WSUM_BITS-1:0] sum_weight;
      logic                 all_flagged;
      logic                 row_last;
   } bin_type;

endpackage

`default_nettype wire

// ----- sv/flagged_weighted_channel_averager.sv -----
// ----------------------------------------------------------------------------
// flagged_weighted_channel_averager
// Flag-aware weighted channel averager: bins complex channel samples and
// returns one weighted average per bin.
//
//   channel   ports                           handshake
//   request   req_* fields                    push / full
//   result    rsp_* fields                    empty / pop
//   config    psel penable pwrite paddr ...   apb write, pready tied high
//
// A sample enters every cycle while full is low; products are
// registered, then summed into the open bin.
// Each closed bin is divided one quotient bit per cycle for real and imaginary
// parts side by side; the divider takes the next bin from the queue only
// after the last result has gone to the output register.
// Reset is synchronous; no clearing pass, the block is ready the cycle after.
// A waiting result holds the finished bin in the divider until it is popped;
// full stalls request only when the queue and the product stage are all occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module flagged_weighted_channel_averager #(
   parameter int MAX_BIN_WIDTH = fwca_pkg::DEF_MAX_BIN_WIDTH,
   parameter int DATA_BITS     = fwca_pkg::DEF_DATA_BITS,
   parameter int WEIGHT_BITS   = fwca_pkg::DEF_WEIGHT_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                push,
   output      logic                                full,
   input  wire logic signed [DATA_BITS-1:0]         req_sample_re,
   input  wire logic signed [DATA_BITS-1:0]         req_sample_im,
   input  wire logic [WEIGHT_BITS-1:0]              req_weight,
   input  wire logic                                req_flagged,
   input  wire logic                                req_row_end,
   // result channel
   output      logic                                empty,
   input  wire logic                                pop,
   output      logic signed [DATA_BITS-1:0]         rsp_avg_re,
   output      logic signed [DATA_BITS-1:0]         rsp_avg_im,
   output      logic [fwca_pkg::WSUM_BITS-1:0]      rsp_weight_total,
   output      logic                                rsp_bin_flagged,
   output      logic                                rsp_row_last,
   // configuration port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [fwca_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [fwca_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output      logic [fwca_pkg::CSR_DATA_BITS-1:0]  prdata,
   output      logic                                pready
);

   localparam int BWB = fwca_pkg::BIN_WIDTH_BITS;
   localparam int CDB = fwca_pkg::CSR_DATA_BITS;

   logic [BWB-1:0]    bin_width_ff, bin_width_in;
   logic              csr_wr, sel_bin_width;
   logic              q_push, q_full, q_valid, q_pop;
   fwca_pkg::bin_type q_wdata, q_rdata;

   // configuration register
   assign pready        = 1'b1;
   assign sel_bin_width = (paddr[2] == fwca_pkg::REG_BIN_WIDTH);
   assign csr_wr        = psel && penable && pwrite && pready;
   assign bin_width_in  = (csr_wr && sel_bin_width) ? pwdata[BWB-1:0] : bin_width_ff;
   assign prdata        = sel_bin_width ? CDB'(bin_width_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff <= fwca_pkg::BIN_WIDTH_RESET;
      end else begin
         bin_width_ff <= bin_width_in;
      end
   end

   // accumulator
   fwca_front #(
      .MAX_BIN_WIDTH (MAX_BIN_WIDTH),
      .DATA_BITS     (DATA_BITS),
      .WEIGHT_BITS   (WEIGHT_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_sample_re (req_sample_re),
      .req_sample_im (req_sample_im),
      .req_weight    (req_weight),
      .req_flagged   (req_flagged),
      .req_row_end   (req_row_end),
      .bin_width     (bin_width_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_wdata)
   );

   // closed bin queue
   fwca_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (q_wdata),
      .is_full  (q_full),
      .rd_valid (q_valid),
      .rd_en    (q_pop),
      .rd_data  (q_rdata)
   );

   // divider and output register
   fwca_back #(
      .DATA_BITS (DATA_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .bin_valid        (q_valid),
      .bin_data         (q_rdata),
      .bin_pop          (q_pop),
      .pop              (pop),
      .empty            (empty),
      .rsp_avg_re       (rsp_avg_re),
      .rsp_avg_im       (rsp_avg_im),
      .rsp_weight_total (rsp_weight_total),
      .rsp_bin_flagged  (rsp_bin_flagged),
      .rsp_row_last     (rsp_row_last)
   );

endmodule

`default_nettype wire

// ----- sv/fwca_front.sv -----
// ----------------------------------------------------------------------------
// fwca_front
// Accepts channel samples, forms the weighted products in a first stage and
// gathers them into bins in a second stage; a closed bin goes to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fwca_front #(
   parameter int MAX_BIN_WIDTH = fwca_pkg::DEF_MAX_BIN_WIDTH,
   parameter int DATA_BITS     = fwca_pkg::DEF_DATA_BITS,
   parameter int WEIGHT_BITS   = fwca_pkg::DEF_WEIGHT_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   output      logic                                  full,
   input  wire logic signed [DATA_BITS-1:0]           req_sample_re,
   input  wire logic signed [DATA_BITS-1:0]           req_sample_im,
   input  wire logic [WEIGHT_BITS-1:0]                req_weight,
   input  wire logic                                  req_flagged,
   input  wire logic                                  req_row_end,
   input  wire logic [fwca_pkg::BIN_WIDTH_BITS-1:0]   bin_width,
   input  wire logic                                  q_full,
   output      logic                                  q_push,
   output      fwca_pkg::bin_type                     q_data
);

   localparam int SB  = fwca_pkg::SUM_BITS;
   localparam int WSB = fwca_pkg::WSUM_BITS;
   localparam int PW  = DATA_BITS + WEIGHT_BITS + 1;
   localparam int EW  = (PW > SB) ? PW : SB;
   localparam int CW  = $clog2(MAX_BIN_WIDTH + 1);

   // product stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [SB-1:0]         s1_pre_ff, s1_pre_in;
   logic [SB-1:0]         s1_pim_ff, s1_pim_in;
   logic [WSB-1:0]        s1_w_ff, s1_w_in;
   logic                  s1_flg_ff, s1_last_ff;
   logic signed [PW-1:0]  pre_full, pim_full;
   logic signed [EW-1:0]  pre_ext, pim_ext;
   logic                  accept, s2_go;

   // accumulate stage
   logic [SB-1:0]   sum_re_ff, sum_re_in;
   logic [SB-1:0]   sum_im_ff, sum_im_in;
   logic [WSB-1:0]  sum_w_ff, sum_w_in;
   logic            keep_flg_ff, keep_flg_in;
   logic            all_flg_ff, all_flg_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   eff_width, count_plus;
   logic [SB-1:0]   nxt_re, nxt_im;
   logic [WSB-1:0]  nxt_w;
   logic            nxt_keep, nxt_all, restart, close;

   // handshake: the product stage moves on unless the queue is full
   assign s2_go  = s1_valid_ff && !q_full;
   assign full   = s1_valid_ff && q_full;
   assign accept = push && !full;

   // weighted products, wrapped to the accumulator width
   assign pre_full  = req_sample_re * $signed({1'b0, req_weight});
   assign pim_full  = req_sample_im * $signed({1'b0, req_weight});
   assign pre_ext   = EW'(pre_full);
   assign pim_ext   = EW'(pim_full);
   assign s1_pre_in = pre_ext[SB-1:0];
   assign s1_pim_in = pim_ext[SB-1:0];
   assign s1_w_in   = WSB'(req_weight);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pre_ff  <= s1_pre_in;
         s1_pim_ff  <= s1_pim_in;
         s1_w_ff    <= s1_w_in;
         s1_flg_ff  <= req_flagged;
         s1_last_ff <= req_row_end;
      end
   end

   // effective bin width: zero counts as one, large values saturate
   always_comb begin
      if (bin_width == '0) begin
         eff_width = CW'(1);
      end else if (32'(bin_width) > MAX_BIN_WIDTH) begin
         eff_width = CW'(MAX_BIN_WIDTH);
      end else begin
         eff_width = CW'(bin_width);
      end
   end

   // bin sums: restart on the first sample or on the first unflagged one
   assign restart    = (count_ff == '0) || (keep_flg_ff && !s1_flg_ff);
   assign count_plus = count_ff + CW'(1);
   assign close      = (count_plus >= eff_width) || s1_last_ff;
   assign nxt_all    = all_flg_ff && s1_flg_ff;

   always_comb begin
      nxt_re   = sum_re_ff;
      nxt_im   = sum_im_ff;
      nxt_w    = sum_w_ff;
      nxt_keep = keep_flg_ff;
      if (restart) begin
         nxt_re   = s1_pre_ff;
         nxt_im   = s1_pim_ff;
         nxt_w    = s1_w_ff;
         nxt_keep = s1_flg_ff;
      end else if (keep_flg_ff == s1_flg_ff) begin
         nxt_re = sum_re_ff + s1_pre_ff;
         nxt_im = sum_im_ff + s1_pim_ff;
         nxt_w  = sum_w_ff + s1_w_ff;
      end
   end

   // state update and bin close
   always_comb begin
      sum_re_in   = sum_re_ff;
      sum_im_in   = sum_im_ff;
      sum_w_in    = sum_w_ff;
      keep_flg_in = keep_flg_ff;
      all_flg_in  = all_flg_ff;
      count_in    = count_ff;
      if (s2_go) begin
         sum_re_in = nxt_re;
         sum_im_in = nxt_im;
         sum_w_in  = nxt_w;
         if (close) begin
            keep_flg_in = 1'b0;
            all_flg_in  = 1'b1;
            count_in    = '0;
         end else begin
            keep_flg_in = nxt_keep;
            all_flg_in  = nxt_all;
            count_in    = count_plus;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_flg_ff <= 1'b0;
         all_flg_ff  <= 1'b1;
         count_ff    <= '0;
      end else begin
         keep_flg_ff <= keep_flg_in;
         all_flg_ff  <= all_flg_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_re_ff <= sum_re_in;
      sum_im_ff <= sum_im_in;
      sum_w_ff  <= sum_w_in;
   end

   // closed bin record
   assign q_push             = s2_go && close;
   assign q_data.sum_re      = nxt_re;
   assign q_data.sum_im      = nxt_im;
   assign q_data.sum_weight  = nxt_w;
   assign q_data.all_flagged = nxt_all;
   assign q_data.row_last    = s1_last_ff;

endmodule

`default_nettype wire

// ----- sv/fwca_queue.sv -----
// ----------------------------------------------------------------------------
// fwca_queue
// Short first-in first-out queue of closed bins between the accumulator and
// the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module fwca_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire fwca_pkg::bin_type  wr_data,
   output      logic               is_full,
   output      logic               rd_valid,
   input  wire logic               rd_en,
   output      fwca_pkg::bin_type  rd_data
);

   localparam int DEPTH = fwca_pkg::QUEUE_DEPTH;
   localparam int PB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NB    = $clog2(DEPTH + 1);

   fwca_pkg::bin_type entry_ff [DEPTH];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NB-1:0] fill_ff, fill_in;
   logic          do_wr, do_rd;

   assign is_full  = (fill_ff == NB'(DEPTH));
   assign rd_valid = (fill_ff != '0);
   assign do_wr    = wr_en && !is_full;
   assign do_rd    = rd_en && rd_valid;
   assign rd_data  = entry_ff[rd_ptr_ff];

   // pointer wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PB'(DEPTH - 1)) ? '0 : wr_ptr_ff + PB'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PB'(DEPTH - 1)) ? '0 : rd_ptr_ff + PB'(1);
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + NB'(1);
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - NB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- sv/fwca_back.sv -----
// ----------------------------------------------------------------------------
// fwca_back
// Divides the real and imaginary bin sums by the weight sum with two
// restoring dividers that retire one quotient bit a cycle, saturates, and
// holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fwca_back #(
   parameter int DATA_BITS = fwca_pkg::DEF_DATA_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                bin_valid,
   input  wire fwca_pkg::bin_type                   bin_data,
   output      logic                                bin_pop,
   input  wire logic                                pop,
   output      logic                                empty,
   output      logic signed [DATA_BITS-1:0]         rsp_avg_re,
   output      logic signed [DATA_BITS-1:0]         rsp_avg_im,
   output      logic [fwca_pkg::WSUM_BITS-1:0]      rsp_weight_total,
   output      logic                                rsp_bin_flagged,
   output      logic                                rsp_row_last
);

   localparam int SB  = fwca_pkg::SUM_BITS;
   localparam int WSB = fwca_pkg::WSUM_BITS;
   localparam int STB = $clog2(SB);
   localparam logic [SB-1:0] LIM = SB'(1) << (DATA_BITS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   typedef struct packed {
      logic [WSB-1:0] rem;
      logic [SB-1:0]  num;
   } div_type;

   logic [1:0]     state_ff, state_in;
   logic [STB-1:0] step_ff, step_in;
   div_type        re_ff, re_in, im_ff, im_in, re_step, im_step;
   logic           neg_re_ff, neg_im_ff;
   logic [WSB-1:0] w_ff;
   logic           flg_ff, last_ff;
   logic           load, deliver;

   logic                         out_valid_ff, out_valid_in;
   logic signed [DATA_BITS-1:0]  avg_re_ff, avg_im_ff;
   logic [WSB-1:0]               wt_ff;
   logic                         oflg_ff, olast_ff;

   // one restoring division step
   function automatic div_type div_step(input div_type cur, input logic [WSB-1:0] d);
      logic [WSB:0] sh;
      logic [WSB:0] diff;
      logic         qbit;
      div_type      nxt;
      sh   = {cur.rem, cur.num[SB-1]};
      diff = sh - {1'b0, d};
      qbit = (sh >= {1'b0, d});
      nxt.rem = qbit ? diff[WSB-1:0] : sh[WSB-1:0];
      nxt.num = {cur.num[SB-2:0], qbit};
      return nxt;
   endfunction

   // magnitude of a two's complement sum
   function automatic logic [SB-1:0] magnitude(input logic [SB-1:0] s);
      return s[SB-1] ? (~s + SB'(1)) : s;
   endfunction

   // saturate the quotient and reapply the sign
   function automatic logic [DATA_BITS-1:0] finish(input logic [SB-1:0] q, input logic neg);
      logic [SB-1:0] qs;
      if (neg) begin
         qs = (q > LIM) ? LIM : q;
         qs = ~qs + SB'(1);
      end else begin
         qs = (q > LIM - SB'(1)) ? LIM - SB'(1) : q;
      end
      return qs[DATA_BITS-1:0];
   endfunction

   assign re_step = div_step(re_ff, w_ff);
   assign im_step = div_step(im_ff, w_ff);
   assign load    = (state_ff == ST_IDLE) && bin_valid;
   assign deliver = (state_ff == ST_HOLD) && (!out_valid_ff || pop);
   assign bin_pop = load;

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (bin_valid) begin
               state_in = ST_DIV;
               step_in  = '0;
            end
         end
         ST_DIV: begin
            step_in = step_ff + STB'(1);
            if (step_ff == STB'(SB - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (deliver) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // divider datapath
   always_comb begin
      re_in = re_ff;
      im_in = im_ff;
      if (load) begin
         re_in.rem = '0;
         re_in.num = magnitude(bin_data.sum_re);
         im_in.rem = '0;
         im_in.num = magnitude(bin_data.sum_im);
      end else if (state_ff == ST_DIV) begin
         re_in = re_step;
         im_in = im_step;
      end
   end

   always_ff @(posedge clock) begin
      re_ff <= re_in;
      im_ff <= im_in;
      if (load) begin
         neg_re_ff <= bin_data.sum_re[SB-1];
         neg_im_ff <= bin_data.sum_im[SB-1];
         w_ff      <= bin_data.sum_weight;
         flg_ff    <= bin_data.all_flagged;
         last_ff   <= bin_data.row_last;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (deliver) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (deliver) begin
         if (w_ff == '0) begin
            avg_re_ff <= '0;
            avg_im_ff <= '0;
         end else begin
            avg_re_ff <= finish(re_ff.num, neg_re_ff);
            avg_im_ff <= finish(im_ff.num, neg_im_ff);
         end
         wt_ff    <= w_ff;
         oflg_ff  <= flg_ff;
         olast_ff <= last_ff;
      end
   end

   assign empty            = !out_valid_ff;
   assign rsp_avg_re       = avg_re_ff;
   assign rsp_avg_im       = avg_im_ff;
   assign rsp_weight_total = wt_ff;
   assign rsp_bin_flagged  = oflg_ff;
   assign rsp_row_last     = olast_ff;

endmodule

`default_nettype wire

// ----- sv/fwca_checker.sv -----
// ----------------------------------------------------------------------------
// fwca_checker
// Port-level checks on the averager, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module fwca_checker #(
   parameter int DATA_BITS = fwca_pkg::DEF_DATA_BITS
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            empty,
   input wire logic                            pop,
   input wire logic [DATA_BITS-1:0]            rsp_avg_re,
   input wire logic [DATA_BITS-1:0]            rsp_avg_im,
   input wire logic [fwca_pkg::WSUM_BITS-1:0]  rsp_weight_total,
   input wire logic                            rsp_bin_flagged,
   input wire logic                            rsp_row_last,
   input wire logic                            pready
);

   // nothing to deliver right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> empty)
      else $error("result shown right after reset");

   // zero weight sum gives zero average
   a_zero_weight_avg: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_weight_total == '0) |-> (rsp_avg_re == '0 && rsp_avg_im == '0))
      else $error("nonzero average with zero weight sum");

   // a waiting result stays until popped
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_avg_re) && $stable(rsp_avg_im)
         && $stable(rsp_weight_total) && $stable(rsp_bin_flagged)
         && $stable(rsp_row_last)))
      else $error("waiting result changed before pop");

   // configuration port never inserts wait states
   a_pready_high: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind flagged_weighted_channel_averager fwca_checker #(
   .DATA_BITS (DATA_BITS)
) u_fwca_checker (
   .clock            (clock),
   .reset            (reset),
   .empty            (empty),
   .pop              (pop),
   .rsp_avg_re       (rsp_avg_re),
   .rsp_avg_im       (rsp_avg_im),
   .rsp_weight_total (rsp_weight_total),
   .rsp_bin_flagged  (rsp_bin_flagged),
   .rsp_row_last     (rsp_row_last),
   .pready           (pready)
);

`default_nettype wire
